/* design/mpf_pkg.sv */
// Package for the magnitude pole finder: sizes, key type, state codes and
// the command and status structs shared by controller and datapath.
// No dependencies.
package mpf_pkg;

  // Array store depth and element compare width
  localparam int MAX_LEN    = 1024;
  localparam int DATA_WIDTH = 32;

  // Fixed field widths of the channels
  localparam int IN_W   = 32;
  localparam int POLE_W = 10;

  // Derived widths: store address and element count (can hold MAX_LEN)
  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int CNT_W = $clog2(MAX_LEN + 1);

  // Offset-binary element key: unsigned compare orders signed values
  typedef logic [DATA_WIDTH-1:0] key_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  localparam key_t KEY_MIN = '0;
  localparam key_t KEY_MAX = '1;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    S_LOAD = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_en;  // element beat accepted this cycle
    logic scan_en;  // backward scan running
    logic emit;     // load result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;  // no read in flight and no entry left to read
    logic out_free;   // output register can take a result this cycle
  } status_t;

endpackage

/* design/mpf_if.sv */
// Channel interfaces of the magnitude pole finder: element input and
// result output, each with valid/ready handshake. Depends on mpf_pkg.
interface mpf_in_if import mpf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] value;
  logic                   last;

  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface

interface mpf_out_if import mpf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              found;
  logic [POLE_W-1:0] pole_index;
  logic              overflow;

  modport source (output valid, found, pole_index, overflow, input ready);
  modport sink   (input valid, found, pole_index, overflow, output ready);
endinterface

/* design/mpf_ctrl.sv */
// Controller of the magnitude pole finder: sequences load, backward scan
// and result hand-off. Depends on mpf_pkg.
module mpf_ctrl import mpf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_last,
  output logic    in_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  // Accept elements only while loading
  assign in_ready    = (state_r == S_LOAD);
  assign cmd.load_en = in_ready && in_valid;
  assign cmd.scan_en = (state_r == S_SCAN);
  assign cmd.emit    = (state_r == S_EMIT) && sts.out_free;

  // Advance on the last element, on scan completion and on result hand-off
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (cmd.load_en && in_last) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_LOAD;
    else        state_r <= state_nxt;
  end

  // A result leaves the controller only after a scan has finished
  a_emit_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && !$past(cmd.emit) |-> $past(sts.scan_done) || $past(state_r == S_EMIT))
    else $error("emit without finished scan");

  // The last element always starts a scan
  a_last_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_en && in_last |=> cmd.scan_en)
    else $error("last element did not start the scan");

  // No element beat while scanning or emitting
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_en || state_r == S_EMIT |-> !cmd.load_en)
    else $error("element accepted while busy");

endmodule

/* design/mpf_datapath.sv */
// Datapath of the magnitude pole finder: element store with prefix bits,
// running prefix max, backward scan with suffix min, output register.
// Depends on mpf_pkg; driven by mpf_ctrl through cmd_t and status_t.
module mpf_datapath import mpf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  output status_t                sts,
  input  logic signed [IN_W-1:0] in_value,
  input  logic                   in_last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_found,
  output logic [POLE_W-1:0]      out_pole_index,
  output logic                   out_overflow
);

  // Store word: prefix bit over element key
  logic [DATA_WIDTH:0] mem [MAX_LEN];
  logic [DATA_WIDTH:0] rd_data_r;

  cnt_t count_r,    count_nxt;
  key_t run_max_r,  run_max_nxt;
  logic ovf_r,      ovf_nxt;
  cnt_t scan_idx_r, scan_idx_nxt;
  logic pend_vld_r, pend_vld_nxt;
  idx_t pend_idx_r, pend_idx_nxt;
  key_t smin_r,     smin_nxt;
  logic found_r,    found_nxt;
  idx_t best_r,     best_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [POLE_W-1:0] out_pole_r,  out_pole_nxt;
  logic              out_ovf_r,   out_ovf_nxt;

  key_t key;
  logic prefix_ok;
  logic store_wr;
  logic rd_en;
  idx_t rd_addr;
  logic rd_ok;
  key_t rd_key;

  // Flip the sign bit so an unsigned compare orders signed values
  assign key       = {~in_value[DATA_WIDTH-1], in_value[DATA_WIDTH-2:0]};
  assign prefix_ok = (key >= run_max_r);
  assign store_wr  = cmd.load_en && (count_r < CNT_W'(MAX_LEN));
  assign rd_en     = cmd.scan_en && (scan_idx_r != '0);
  assign rd_addr   = IDX_W'(scan_idx_r - 1'b1);
  assign rd_ok     = rd_data_r[DATA_WIDTH];
  assign rd_key    = rd_data_r[DATA_WIDTH-1:0];

  assign sts.scan_done = (scan_idx_r == '0) && !pend_vld_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  // Store port: one write while loading, one registered read while scanning
  always_ff @(posedge clk) begin
    if (store_wr) mem[count_r[IDX_W-1:0]] <= {prefix_ok, key};
    if (rd_en)    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    count_nxt     = count_r;
    run_max_nxt   = run_max_r;
    ovf_nxt       = ovf_r;
    scan_idx_nxt  = scan_idx_r;
    pend_vld_nxt  = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    smin_nxt      = smin_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_pole_nxt  = out_pole_r;
    out_ovf_nxt   = out_ovf_r;

    // Load: count or flag overflow, track prefix max
    if (cmd.load_en) begin
      if (store_wr) count_nxt = count_r + 1'b1;
      else          ovf_nxt   = 1'b1;
      if (key > run_max_r) run_max_nxt = key;
      // Arm the scan; an overflowed array has nothing to scan
      if (in_last) begin
        scan_idx_nxt = ovf_nxt ? '0 : count_nxt;
        smin_nxt     = KEY_MAX;
        found_nxt    = 1'b0;
        best_nxt     = '0;
      end
    end

    // Scan: issue the next read downward
    if (rd_en) begin
      scan_idx_nxt = scan_idx_r - 1'b1;
      pend_vld_nxt = 1'b1;
      pend_idx_nxt = rd_addr;
    end

    // Scan: check the returned entry against the suffix min
    if (pend_vld_r) begin
      if (rd_ok && (rd_key <= smin_r)) begin
        found_nxt = 1'b1;
        best_nxt  = pend_idx_r;
      end
      if (rd_key < smin_r) smin_nxt = rd_key;
    end

    // Drop the result once taken
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    // Emit: load the result, clear the array state
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = found_r && !ovf_r;
      out_pole_nxt  = (found_r && !ovf_r) ? POLE_W'(best_r) : '0;
      out_ovf_nxt   = ovf_r;
      count_nxt     = '0;
      run_max_nxt   = KEY_MIN;
      ovf_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      run_max_r   <= KEY_MIN;
      ovf_r       <= 1'b0;
      scan_idx_r  <= '0;
      pend_vld_r  <= 1'b0;
      smin_r      <= KEY_MAX;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      run_max_r   <= run_max_nxt;
      ovf_r       <= ovf_nxt;
      scan_idx_r  <= scan_idx_nxt;
      pend_vld_r  <= pend_vld_nxt;
      smin_r      <= smin_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_idx_r  <= pend_idx_nxt;
    best_r      <= best_nxt;
    out_found_r <= out_found_nxt;
    out_pole_r  <= out_pole_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_pole_index = out_pole_r;
  assign out_overflow   = out_ovf_r;

  // Element count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_LEN))
    else $error("element count beyond store depth");

  // The scan only reads entries written for this array
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    scan_idx_r <= count_r)
    else $error("scan index beyond element count");

  // A found pole lies inside the loaded array
  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    found_r && cmd.scan_en |-> {1'b0, best_r} < count_r)
    else $error("pole index outside the array");

  // An overflow result never reports a pole
  a_ovf_no_pole: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ovf_r |-> !out_found_r && out_pole_r == '0)
    else $error("overflow result carries a pole");

  // Emit leaves the next array starting empty
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> count_r == '0 && !ovf_r)
    else $error("array state not cleared after emit");

endmodule

/* design/magnitude_pole_finder.sv */
// Magnitude pole finder. Elements stream in on in_ch, one beat per cycle
// while loading, with last marking the final element; each array gives
// one result beat on out_ch. An array of stored elements is loaded, then
// scanned backward through the single store port (one read per cycle,
// read data registered, the last entry folded in and the scan seen
// finished after the final read), and the result is loaded into the
// output register. An array longer than the 1024-entry store skips the
// store reads and reports overflow with found = 0. The finished result
// sits in an output register, so loading of the next array starts while
// it waits to be taken. No clearing pass after reset.
// Depends on mpf_pkg, mpf_if, mpf_ctrl and mpf_datapath.
module magnitude_pole_finder import mpf_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  mpf_in_if.sink          in_ch,
  mpf_out_if.source       out_ch
);

  cmd_t    cmd;
  status_t sts;

  // Sequence load, scan and hand-off
  mpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Store, compare and hold the result
  mpf_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_value       (in_ch.value),
    .in_last        (in_ch.last),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_found      (out_ch.found),
    .out_pole_index (out_ch.pole_index),
    .out_overflow   (out_ch.overflow)
  );

endmodule

/* tb/mpf_scoreboard_pkg.sv */
`timescale 1ns / 100ps
// Scoreboard for the magnitude pole finder test: predicts the pole result
// of each array from its element beats and checks result beats in order.
// Depends on mpf_pkg.
package mpf_scoreboard_pkg;
  import mpf_pkg::*;

  typedef struct {
    logic              found;
    logic [POLE_W-1:0] pole_index;
    logic              overflow;
  } pole_result_t;

  class pole_scoreboard;
    // Current array as offset-binary keys, with the prefix flag per index
    key_t        element_keys [MAX_LEN];
    bit          above_prefix [MAX_LEN];
    key_t        prefix_max;
    int unsigned stored_count;
    bit          too_long;

    pole_result_t pending_poles [$];
    int unsigned  mismatches;

    function new();
      mismatches = 0;
      start_array();
    endfunction

    function void start_array();
      prefix_max   = KEY_MIN;
      stored_count = 0;
      too_long     = 1'b0;
    endfunction

    // Add one accepted element beat; on the last one, queue the pole result
    function void note_element(logic [IN_W-1:0] value, logic last);
      key_t         k;
      key_t         suffix_low;
      int           best;
      pole_result_t want;
      k = {~value[DATA_WIDTH-1], value[DATA_WIDTH-2:0]};
      if (stored_count < MAX_LEN) begin
        element_keys[stored_count] = k;
        above_prefix[stored_count] = (k >= prefix_max);
        stored_count++;
      end else begin
        too_long = 1'b1;
      end
      if (k > prefix_max) prefix_max = k;
      if (!last) return;

      want.found      = 1'b0;
      want.pole_index = '0;
      want.overflow   = too_long;
      if (!too_long) begin
        // Scan backward keeping the suffix minimum; the last hit is lowest
        best       = -1;
        suffix_low = KEY_MAX;
        for (int i = int'(stored_count) - 1; i >= 0; i--) begin
          if (above_prefix[i] && element_keys[i] <= suffix_low) best = i;
          if (element_keys[i] < suffix_low) suffix_low = element_keys[i];
        end
        if (best >= 0) begin
          want.found      = 1'b1;
          want.pole_index = POLE_W'(best);
        end
      end
      pending_poles.push_back(want);
      start_array();
    endfunction

    // Compare one result beat against the oldest predicted pole
    function void check_pole(logic found, logic [POLE_W-1:0] pole_index, logic overflow);
      pole_result_t want;
      if (pending_poles.size() == 0) begin
        $error("result beat with no array pending: found=%0d pole_index=%0d overflow=%0d",
               found, pole_index, overflow);
        mismatches++;
        return;
      end
      want = pending_poles.pop_front();
      if (found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, found);
        mismatches++;
      end
      if (pole_index !== want.pole_index) begin
        $error("pole_index: expected %0d, actual %0d", want.pole_index, pole_index);
        mismatches++;
      end
      if (overflow !== want.overflow) begin
        $error("overflow: expected %0d, actual %0d", want.overflow, overflow);
        mismatches++;
      end
    endfunction
  endclass

endpackage

/* tb/magnitude_pole_finder_test.sv */
`timescale 1ns / 100ps
// Top of the magnitude pole finder test: directed and random arrays under
// varying source and sink idling, checked by the pole scoreboard.
// Depends on mpf_pkg, mpf_if, magnitude_pole_finder and mpf_scoreboard_pkg.
module magnitude_pole_finder_test;
  import mpf_pkg::*;
  import mpf_scoreboard_pkg::*;

  localparam int RANDOM_END   = 1540;  // element count where short arrays stop
  localparam int PHASE1_START = 360;
  localparam int PHASE2_START = 1400;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 2 * MAX_LEN + 8;

  typedef enum int {
    PHASE_SLOW_SINK,    // sender idles lightly, receiver heavily
    PHASE_SLOW_SOURCE,  // the other way round
    PHASE_STREAM        // no idling on either side
  } idle_phase_e;

  typedef enum int {
    SHAPE_NOISE,
    SHAPE_TIES,
    SHAPE_ASCENDING,
    SHAPE_PIVOT,
    SHAPE_EXTREME
  } array_shape_e;

  logic clk = 1'b0;
  logic rst_n;

  mpf_in_if  in_ch ();
  mpf_out_if out_ch ();

  magnitude_pole_finder dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  pole_scoreboard board = new();
  idle_phase_e    idle_phase = PHASE_SLOW_SINK;
  int             elements_sent = 0;

  logic [IN_W-1:0] extreme_values [5] = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                                          32'h0000_0000, 32'h0000_0001};

  // Clock: 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offer one element beat, with random idle cycles ahead of it
  task automatic send_element(input logic [IN_W-1:0] value, input logic last);
    int idle_pct;
    idle_pct = (idle_phase == PHASE_SLOW_SINK)   ? 24 :
               (idle_phase == PHASE_SLOW_SOURCE) ? 72 : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    in_ch.last  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_element(value, last);
    elements_sent++;
    if (elements_sent >= PHASE2_START)      idle_phase = PHASE_STREAM;
    else if (elements_sent >= PHASE1_START) idle_phase = PHASE_SLOW_SOURCE;
  endtask

  // Stimulus
  initial begin
    int              len;
    int              pole_at;
    int              pivot;
    int              cur;
    bit              long_sent;
    array_shape_e    shape;
    logic [IN_W-1:0] v;

    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.last  = 1'b0;
    rst_n       = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One-element arrays at zero and both extremes
    send_element(32'h0000_0000, 1'b1);
    send_element(32'h8000_0000, 1'b1);
    send_element(32'h7fff_ffff, 1'b1);
    // Falling pair has no pole; rising pair has it at the first index
    send_element(32'h7fff_ffff, 1'b0);
    send_element(32'h8000_0000, 1'b1);
    send_element(32'h8000_0000, 1'b0);
    send_element(32'h7fff_ffff, 1'b1);
    // Ties satisfy both sides
    send_element(32'd5, 1'b0);
    send_element(32'd5, 1'b0);
    send_element(32'd5, 1'b1);
    // Pole at the last index
    send_element(32'd3, 1'b0);
    send_element(32'd1, 1'b0);
    send_element(32'd2, 1'b0);
    send_element(32'd4, 1'b1);
    // Pole in the middle next to a tie
    send_element(32'd2, 1'b0);
    send_element(32'd1, 1'b0);
    send_element(32'd3, 1'b0);
    send_element(32'd3, 1'b0);
    send_element(32'd5, 1'b0);
    send_element(32'd4, 1'b1);

    // Short random arrays of mixed shapes, with one array past the store
    // depth once the first phase is over
    long_sent = 1'b0;
    while (elements_sent < RANDOM_END) begin
      if (!long_sent && elements_sent >= PHASE1_START) begin
        // One to six elements past the store depth: overflow
        len = MAX_LEN + $urandom_range(1, 6);
        for (int i = 0; i < len; i++) send_element($urandom(), i == len - 1);
        long_sent = 1'b1;
      end else begin
        len     = ($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        shape   = array_shape_e'($urandom_range(SHAPE_EXTREME));
        pole_at = $urandom_range(len - 1);
        pivot   = int'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
        cur     = int'($urandom_range(2000)) - 1000;
        for (int i = 0; i < len; i++) begin
          case (shape)
            SHAPE_NOISE: v = $urandom();
            SHAPE_TIES:  v = int'($urandom_range(7)) - 4;
            SHAPE_ASCENDING: begin
              v = cur;
              cur += $urandom_range(3);
            end
            SHAPE_PIVOT: begin
              if (i < pole_at)       v = pivot - int'($urandom_range(50));
              else if (i == pole_at) v = pivot;
              else                   v = pivot + int'($urandom_range(50));
            end
            default: v = extreme_values[$urandom_range(4)];
          endcase
          send_element(v, i == len - 1);
        end
      end
    end

    // Drain and report
    in_ch.valid <= 1'b0;
    while (board.pending_poles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Result sink: check accepted beats, then pick the next ready
  initial begin
    int hold_left;
    bit hold_done;
    int idle_pct;
    hold_left    = 0;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        board.check_pole(out_ch.found, out_ch.pole_index, out_ch.overflow);
      // Hold off once for a long stretch so the block backs up its input
      if (idle_phase == PHASE_STREAM && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      idle_pct = (idle_phase == PHASE_SLOW_SINK)   ? 72 :
                 (idle_phase == PHASE_SLOW_SOURCE) ? 24 : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
